[hdl/ctir_pkg.sv]
// ----------------------------------------------------------------------------
// ctir_pkg
// Shared constants, types and helpers for the cubic table interpolator.
// ----------------------------------------------------------------------------
package ctir_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned NUM_BANKS   = 4;
  localparam int unsigned BANK_ROWS   = TABLE_DEPTH / NUM_BANKS;
  localparam int unsigned ROW_W       = ADDR_W - 2;
  localparam int unsigned LEN_W       = ADDR_W + 1;
  localparam int unsigned IP_W        = 33 - FRAC_BITS;

  // Configuration register indexes
  localparam logic CFG_TABLE_LENGTH = 1'b0;
  localparam logic CFG_ONSET_OFFSET = 1'b1;

  // Item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Per-read control carried from the address stage into the datapath
  typedef struct packed {
    logic        short_tbl;
    logic [1:0]  rot;
    logic [16:0] frac;
  } ctir_ctl_t;

  // Exact floor(x / 3) for 20-bit unsigned x via reciprocal multiply
  function automatic logic [18:0] div3(input logic [19:0] x);
    logic [39:0] p;
    p = x * 20'd699051;
    return p[39:21];
  endfunction

endpackage

[hdl/ctir_bank_ram.sv]
// ----------------------------------------------------------------------------
// ctir_bank_ram
// One bank of the sample table: single port, registered read data.
// ----------------------------------------------------------------------------
module ctir_bank_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [ctir_pkg::ROW_W-1:0] addr_i,
  input  logic [15:0]              wdata_i,
  output logic [15:0]              rdata_o
);

  logic [15:0] mem [ctir_pkg::BANK_ROWS];

  // Write the entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Register the read data, hold it otherwise
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

[hdl/ctir_kernel.sv]
// ----------------------------------------------------------------------------
// ctir_kernel
// Cubic Lagrange arithmetic pipeline: bank data in, saturated sample out.
// ----------------------------------------------------------------------------
module ctir_kernel (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ctir_pkg::ctir_ctl_t ctl_i,
  input  logic [15:0]         bank_data_i [4],
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         value_o
);

  logic [8:2] v_q;
  logic [9:2] rdy;

  // Bubble-collapsing ready chain
  always_comb begin
    rdy[9] = out_ready_i;
    for (int k = 8; k >= 2; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign in_ready_o  = rdy[2];
  assign out_valid_o = v_q[8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[2]) v_q[2] <= in_valid_i;
      for (int k = 3; k <= 8; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 2: bank data with its control
  ctir_pkg::ctir_ctl_t ctl2_q;
  always_ff @(posedge clk_i) begin
    if (rdy[2] && in_valid_i) ctl2_q <= ctl_i;
  end

  logic signed [15:0] a2, b2, c2, d2;
  logic signed [16:0] m2;
  logic signed [18:0] t1_2, t2_2;
  logic signed [17:0] f2;
  always_comb begin
    a2   = bank_data_i[ctl2_q.rot];
    b2   = bank_data_i[2'(ctl2_q.rot + 2'd1)];
    c2   = bank_data_i[2'(ctl2_q.rot + 2'd2)];
    d2   = bank_data_i[2'(ctl2_q.rot + 2'd3)];
    m2   = 17'(c2) - 17'(b2);
    t1_2 = 19'(d2) - 19'(a2) - 19'(m2) - 19'(m2) - 19'(m2);
    t2_2 = 19'(d2) + 19'(a2) + 19'(a2) - 19'(b2) - 19'(b2) - 19'(b2);
    f2   = $signed({1'b0, ctl2_q.frac});
  end

  // Stage 3: first product
  logic signed [36:0] p1_q;
  logic signed [18:0] t2_3_q;
  logic [16:0]        f3_q, f4_q, f5_q, f6_q;
  logic signed [15:0] b3_q, b4_q, b5_q, b6_q, b7_q;
  logic signed [16:0] m3_q, m4_q, m5_q, m6_q;
  logic               sh3_q, sh4_q, sh5_q, sh6_q, sh7_q;
  always_ff @(posedge clk_i) begin
    if (rdy[3] && v_q[2]) begin
      p1_q   <= t1_2 * f2;
      t2_3_q <= t2_2;
      f3_q   <= ctl2_q.frac;
      b3_q   <= b2;
      m3_q   <= m2;
      sh3_q  <= ctl2_q.short_tbl;
    end
  end

  // Stage 4: s1 times (one - f)
  logic signed [37:0] s1_3;
  logic signed [17:0] g3;
  logic signed [55:0] prod2_q;
  always_comb begin
    s1_3 = 38'(p1_q) + (38'(t2_3_q) <<< 16);
    g3   = 18'sd65536 - $signed({1'b0, f3_q});
  end
  always_ff @(posedge clk_i) begin
    if (rdy[4] && v_q[3]) begin
      prod2_q <= s1_3 * g3;
      f4_q    <= f3_q;
      b4_q    <= b3_q;
      m4_q    <= m3_q;
      sh4_q   <= sh3_q;
    end
  end

  // Stage 5: round, bias positive, divide high part by three
  logic signed [55:0] rs4;
  logic signed [38:0] z4, u4;
  logic [19:0]        hi4, rem4;
  logic [18:0]        q1_4;
  logic [18:0]        q1_q;
  logic [1:0]         r1_q;
  logic [17:0]        zl_q;
  always_comb begin
    rs4  = prod2_q + 56'sd196608;
    z4   = rs4[55:17];
    u4   = z4 + 39'sh30_0000_0000;
    hi4  = u4[37:18];
    q1_4 = ctir_pkg::div3(hi4);
    rem4 = hi4 - {q1_4, 1'b0} - 20'(q1_4);
  end
  always_ff @(posedge clk_i) begin
    if (rdy[5] && v_q[4]) begin
      q1_q  <= q1_4;
      r1_q  <= rem4[1:0];
      zl_q  <= u4[17:0];
      f5_q  <= f4_q;
      b5_q  <= b4_q;
      m5_q  <= m4_q;
      sh5_q <= sh4_q;
    end
  end

  // Stage 6: finish the divide, remove the bias
  logic [18:0]        q2_5;
  logic [36:0]        quo5;
  logic signed [37:0] s3_q;
  always_comb begin
    q2_5 = ctir_pkg::div3({r1_q, zl_q});
    quo5 = {q1_q[18:0], 18'd0} + 37'(q2_5);
  end
  always_ff @(posedge clk_i) begin
    if (rdy[6] && v_q[5]) begin
      s3_q  <= $signed({1'b0, quo5}) - 38'sh10_0000_0000;
      f6_q  <= f5_q;
      b6_q  <= b5_q;
      m6_q  <= m5_q;
      sh6_q <= sh5_q;
    end
  end

  // Stage 7: f times (m - s3)
  logic signed [39:0] w6;
  logic signed [57:0] prod3_q;
  always_comb begin
    w6 = (40'(m6_q) <<< 16) - 40'(s3_q);
  end
  always_ff @(posedge clk_i) begin
    if (rdy[7] && v_q[6]) begin
      prod3_q <= w6 * $signed({1'b0, f6_q});
      b7_q    <= b6_q;
      sh7_q   <= sh6_q;
    end
  end

  // Stage 8: round, add b, saturate (zero for a short table) into the output register
  logic signed [57:0] rs7;
  logic signed [25:0] r7;
  logic [15:0]        val7;
  always_comb begin
    rs7 = prod3_q + (58'sd1 <<< 31);
    r7  = rs7[57:32] + 26'(b7_q);
    if (sh7_q) begin
      val7 = 16'd0;
    end else if (r7 > 26'sd32767) begin
      val7 = 16'h7fff;
    end else if (r7 < -26'sd32768) begin
      val7 = 16'h8000;
    end else begin
      val7 = r7[15:0];
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy[8] && v_q[7]) value_o <= val7;
  end

endmodule

[hdl/cubic_table_interpolator_top.sv]
// Pipeline: a read beat is captured in the stage-1 register, the banks register its
//   four samples, and the kernel stages carry it to the result register.
// Throughput: one beat (read or write) per cycle while no read is held at stage 1
//   by a stalled kernel; the four-bank table serves one position's four neighbor reads in the same cycle.
// Reset: clears the pipeline valid bits and both configuration registers;
//   the sample table is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// cubic_table_interpolator_top
// Sample table with four-point cubic interpolated reads at fractional position.
// ----------------------------------------------------------------------------
module cubic_table_interpolator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [11:0] write_address_i,
  input  logic [15:0] write_sample_i,
  input  logic [31:0] read_position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] interpolated_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Configuration registers
  logic [ctir_pkg::LEN_W-1:0] table_length_q;
  logic signed [31:0]         onset_offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= '0;
      onset_offset_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ctir_pkg::CFG_TABLE_LENGTH: table_length_q <= cfg_data_i[ctir_pkg::LEN_W-1:0];
        ctir_pkg::CFG_ONSET_OFFSET: onset_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: capture the beat with the offset position
  logic               v1_q;
  logic               func1_q;
  logic [11:0]        waddr1_q;
  logic [15:0]        wsmp1_q;
  logic signed [32:0] pos1_q;
  logic               k_ready;
  logic               s1_go;
  logic               rd_go;

  assign rd_go      = v1_q && (func1_q == ctir_pkg::FUNC_READ) && k_ready;
  assign s1_go      = v1_q && ((func1_q == ctir_pkg::FUNC_WRITE) || k_ready);
  assign in_ready_o = !v1_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_ready_o) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      func1_q  <= func_i;
      waddr1_q <= write_address_i;
      wsmp1_q  <= write_sample_i;
      pos1_q   <= 33'($signed(read_position_i)) + 33'(onset_offset_q);
    end
  end

  // Clamp the position, split into index and fraction
  logic [ctir_pkg::LEN_W-1:0]      len_eff;
  logic [ctir_pkg::LEN_W-1:0]      maxidx;
  logic [ctir_pkg::IP_W-1:0]       ipraw;
  logic [ctir_pkg::FRAC_BITS+15:0] fwide;
  logic [ctir_pkg::ADDR_W-1:0]     idx;
  logic [ctir_pkg::ADDR_W-1:0]     base;
  ctir_pkg::ctir_ctl_t             ctl;

  always_comb begin
    if (table_length_q > ctir_pkg::LEN_W'(ctir_pkg::TABLE_DEPTH)) begin
      len_eff = ctir_pkg::LEN_W'(ctir_pkg::TABLE_DEPTH);
    end else begin
      len_eff = table_length_q;
    end
    maxidx        = len_eff - ctir_pkg::LEN_W'(3);
    ipraw         = pos1_q[32:ctir_pkg::FRAC_BITS];
    fwide         = {pos1_q[ctir_pkg::FRAC_BITS-1:0], 16'd0};
    ctl.short_tbl = len_eff < ctir_pkg::LEN_W'(4);
    if (pos1_q < (33'sd1 <<< ctir_pkg::FRAC_BITS)) begin
      idx      = ctir_pkg::ADDR_W'(1);
      ctl.frac = 17'd0;
    end else if (ipraw > ctir_pkg::IP_W'(maxidx)) begin
      idx      = maxidx[ctir_pkg::ADDR_W-1:0];
      ctl.frac = 17'd65536;
    end else begin
      idx      = ipraw[ctir_pkg::ADDR_W-1:0];
      ctl.frac = {1'b0, fwide[ctir_pkg::FRAC_BITS+15 -: 16]};
    end
    base    = idx - ctir_pkg::ADDR_W'(1);
    ctl.rot = base[1:0];
  end

  // Table banks: entry e lives in bank e[1:0], row e[ADDR_W-1:2]
  logic [15:0] bank_data [4];
  logic        wr_go;
  assign wr_go = v1_q && (func1_q == ctir_pkg::FUNC_WRITE)
                 && ({1'b0, waddr1_q} < 13'(ctir_pkg::TABLE_DEPTH));

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [1:0]                  ofs;
    logic [ctir_pkg::ADDR_W-1:0] ent;
    logic                        we;
    logic [ctir_pkg::ROW_W-1:0]  addr;

    always_comb begin
      ofs  = 2'(k) - base[1:0];
      ent  = base + ctir_pkg::ADDR_W'(ofs);
      we   = wr_go && (waddr1_q[1:0] == 2'(k));
      addr = we ? waddr1_q[ctir_pkg::ADDR_W-1:2] : ent[ctir_pkg::ADDR_W-1:2];
    end

    ctir_bank_ram u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .re_i    (rd_go),
      .addr_i  (addr),
      .wdata_i (wsmp1_q),
      .rdata_o (bank_data[k])
    );
  end

  // Interpolation datapath
  ctir_kernel u_kernel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rd_go),
    .in_ready_o  (k_ready),
    .ctl_i       (ctl),
    .bank_data_i (bank_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (interpolated_value_o)
  );

endmodule

[hdl/ctir_checker.sv]
// ----------------------------------------------------------------------------
// ctir_checker
// Port-level checks for the cubic table interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module ctir_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] interpolated_value_o,
  input logic        cfg_ready_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(interpolated_value_o))
    else $error("result payload changed while stalled");

  // Show no result once reset has taken effect
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // Take configuration beats at any time
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port stalled");

endmodule

bind cubic_table_interpolator_top ctir_checker u_ctir_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .interpolated_value_o (interpolated_value_o),
  .cfg_ready_o          (cfg_ready_o)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the cubic table interpolator. Fills part of the sample table,
// sets length and onset, and sends directed and random write and read beats.
// Each read result is checked against an in-bench fixed-point interpolation.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned LATENCY   = 8;
  localparam int unsigned WDOG_MAX  = 4000;
  localparam int          FILL_LEN  = 256;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        func_i;
  logic [11:0] write_address_i;
  logic [15:0] write_sample_i;
  logic [31:0] read_position_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] interpolated_value_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;

  // Predictor state
  logic signed [15:0] tbl_model [ctir_pkg::TABLE_DEPTH];
  bit                 tbl_written [ctir_pkg::TABLE_DEPTH];
  logic [12:0]        len_model;
  logic signed [31:0] onset_model;

  logic signed [15:0] expected_values [$];
  int                 fail_count;
  int                 idle_cycles;
  int                 send_idle_pct;
  int                 recv_idle_pct;

  cubic_table_interpolator_top dut (.*);

  // Clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Round half up of x / den, den > 0
  function automatic longint round_div(longint x, longint den);
    longint num;
    num = x + den / 2;
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic int unsigned eff_length();
    return (len_model > ctir_pkg::TABLE_DEPTH) ? ctir_pkg::TABLE_DEPTH : len_model;
  endfunction

  // Left-center table index for one read position, after clamping
  function automatic longint read_index(logic signed [31:0] pos_in);
    longint len, pos, ip;
    len = eff_length();
    pos = longint'(pos_in) + longint'(onset_model);
    if (pos < 65536) return 1;
    ip = pos >>> ctir_pkg::FRAC_BITS;
    if (ip > len - 3) ip = len - 3;
    return ip;
  endfunction

  // True when a read touches only entries that were written
  function automatic bit read_is_covered(logic [31:0] pos);
    longint ip;
    if (eff_length() < 4) return 1'b1;
    ip = read_index(pos);
    return tbl_written[ip - 1] && tbl_written[ip] && tbl_written[ip + 1]
           && tbl_written[ip + 2];
  endfunction

  // Interpolated sample for one read position
  function automatic logic signed [15:0] interpolate(logic signed [31:0] pos_in);
    longint len, pos, ip, f, a, b, c, d, m, s1, s3, r;
    len = eff_length();
    if (len < 4) return '0;
    pos = longint'(pos_in) + longint'(onset_model);
    if (pos < 65536) begin
      ip = 1;
      f  = 0;
    end else begin
      ip = pos >>> ctir_pkg::FRAC_BITS;
      if (ip > len - 3) begin
        ip = len - 3;
        f  = 65536;
      end else begin
        f = pos & 64'hFFFF;
      end
    end
    a = tbl_model[ip - 1];
    b = tbl_model[ip];
    c = tbl_model[ip + 1];
    d = tbl_model[ip + 2];
    m  = c - b;
    s1 = (d - a - 3 * m) * f + (d + 2 * a - 3 * b) * 65536;
    s3 = round_div((65536 - f) * s1, 6 * 65536);
    r  = b + round_div(f * (m * 65536 - s3), 64'sd1 << 32);
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Send one item; predict on acceptance; valid stays up for a following beat
  task automatic send_beat(logic fn, logic [11:0] addr, logic [15:0] smp,
                           logic [31:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= fn;
    write_address_i <= addr;
    write_sample_i  <= smp;
    read_position_i <= pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (fn == ctir_pkg::FUNC_WRITE) begin
      tbl_model[addr]   = smp;
      tbl_written[addr] = 1'b1;
    end else begin
      expected_values.push_back(interpolate(pos));
    end
    @(negedge clk_i);
  endtask

  task automatic write_sample(int addr, logic [15:0] smp);
    send_beat(ctir_pkg::FUNC_WRITE, addr[11:0], smp, $urandom());
  endtask

  task automatic read_at(logic [31:0] pos);
    send_beat(ctir_pkg::FUNC_READ, 12'($urandom()), 16'($urandom()), pos);
  endtask

  // Drop valid, wait until all results are in, then let the pipeline drain
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_values.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == ctir_pkg::CFG_TABLE_LENGTH) len_model = data[12:0];
    else onset_model = data;
    @(negedge clk_i);
  endtask

  task automatic set_config(logic [12:0] len, logic [31:0] onset);
    drain();
    write_reg(ctir_pkg::CFG_TABLE_LENGTH, {19'd0, len});
    write_reg(ctir_pkg::CFG_ONSET_OFFSET, onset);
    cfg_valid_i <= 1'b0;
  endtask

  // Random position that mostly lands inside the table, sometimes anywhere
  function automatic logic [31:0] rand_pos();
    int unsigned len;
    len = eff_length();
    case ($urandom_range(9))
      0: return $urandom();
      1: return {16'($urandom_range(len + 3)), 16'hFFFF};
      2: return {16'($urandom_range(len + 3)), 16'h0000};
      default: return {4'd0, 12'($urandom_range(len)), 16'($urandom())};
    endcase
  endfunction

  // Fill the low region and the top four entries
  task automatic test_fill_table();
    for (int i = 0; i < FILL_LEN; i++) write_sample(i, 16'($urandom()));
    for (int i = int'(ctir_pkg::TABLE_DEPTH) - 4; i < int'(ctir_pkg::TABLE_DEPTH); i++) begin
      write_sample(i, 16'($urandom()));
    end
  endtask

  // Extremes of samples and positions, clamps, short table
  task automatic test_directed();
    set_config(13'd3, 32'd0);
    read_at(32'h0002_8000);
    set_config(13'd8, 32'd0);
    write_sample(1, 16'h7FFF);
    write_sample(2, 16'h8000);
    write_sample(3, 16'h7FFF);
    write_sample(4, 16'h8000);
    write_sample(5, 16'h8000);
    write_sample(6, 16'h7FFF);
    read_at(32'h0001_8000);
    read_at(32'h0002_FFFF);
    read_at(32'h0003_0001);
    read_at(32'h0000_FFFF);
    read_at(32'h8000_0000);
    read_at(32'h7FFF_FFFF);
    read_at(32'h0005_0000);
    read_at(32'h0006_0000);
    read_at(32'h0004_C000);
    write_sample(12'hFFF, 16'h0000);
    set_config(13'd4096, 32'h7FFF_FFFF);
    read_at(32'h8000_0000);
    read_at(32'h7FFF_FFFF);
    set_config(13'h1FFF, 32'h8000_0000);
    read_at(32'h7FFF_FFFF);
    read_at(32'h8000_0000);
    set_config(13'd4, 32'hFFFF_8000);
    read_at(32'h0001_C000);
  endtask

  // Random mix of writes and reads over several configurations
  task automatic test_random(int items);
    int          n;
    logic [31:0] pos;
    n = 0;
    while (n < items) begin
      if (n % 120 == 0) begin
        case ($urandom_range(4))
          0: set_config(13'($urandom_range(4, 16)), $urandom_range(0, 3) << 16);
          1: set_config(13'($urandom()), $urandom());
          2: set_config(13'($urandom_range(4097, 8191)), 32'($urandom_range(0, 65535)));
          default: set_config(13'($urandom_range(4, FILL_LEN)),
                              32'(-$urandom_range(0, 200000)));
        endcase
      end
      if (n == items / 2) drain();
      if ($urandom_range(3) == 0) begin
        write_sample(int'($urandom_range(ctir_pkg::TABLE_DEPTH - 1)), 16'($urandom()));
      end else begin
        // Steer reads of unwritten entries to the low clamp
        pos = rand_pos();
        if (!read_is_covered(pos)) pos = 32'h8000_0000;
        read_at(pos);
      end
      n++;
    end
  endtask

  // Result checker and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_values.size() == 0) begin
        $error("interpolated_value: unexpected result %0d", $signed(interpolated_value_o));
        fail_count++;
      end else begin
        logic signed [15:0] exp_v;
        exp_v = expected_values.pop_front();
        if (interpolated_value_o !== exp_v) begin
          $error("interpolated_value: expected %0d, actual %0d", exp_v,
                 $signed(interpolated_value_o));
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_valid_i      = 1'b0;
    func_i          = ctir_pkg::FUNC_WRITE;
    write_address_i = '0;
    write_sample_i  = '0;
    read_position_i = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = ctir_pkg::CFG_TABLE_LENGTH;
    cfg_data_i      = '0;
    out_ready_i     = 1'b1;
    len_model       = '0;
    onset_model     = '0;
    fail_count      = 0;
    idle_cycles     = 0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    rst_ni          = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_fill_table();
    test_directed();
    send_idle_pct = 34;
    recv_idle_pct = 69;
    test_random(225);
    send_idle_pct = 69;
    recv_idle_pct = 34;
    test_random(225);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(225);
    drain();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ctir_pkg.sv
hdl/ctir_bank_ram.sv
hdl/ctir_kernel.sv
hdl/cubic_table_interpolator_top.sv
hdl/ctir_checker.sv
test/tb_top.sv
